/* rtl/rmx_pkg.sv */
package rmx_pkg;

  localparam int MAX_ITEMS_DEF  = 16384;
  localparam int VALUE_BITS_DEF = 24;
  localparam int NODE_COUNT_DEF = 409625;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_INIT,
    DP_LOAD,
    DP_APP,
    DP_BRD,
    DP_BWR,
    DP_LEAF,
    DP_REFUSE_FULL,
    DP_REFUSE_BAD,
    DP_QRY,
    DP_QRW,
    DP_QRN,
    DP_QALT,
    DP_QCHK,
    DP_QDIR,
    DP_QPREF,
    DP_QPW,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic full;
    logic bad;
    logic last;
    logic alt_ok;
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_BRD,
    S_BWR,
    S_LEAF,
    S_IDLE,
    S_CHECK,
    S_QRW,
    S_QRN,
    S_QALT,
    S_QCHK,
    S_QDIR,
    S_QPREF,
    S_QPW,
    S_OUT
  } ctl_state_t;

endpackage

/* rtl/rmx_ram.sv */
module rmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

/* rtl/rmx_ctrl.sv */
module rmx_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  rmx_pkg::status_t sts,
  output rmx_pkg::cmd_t    cmd
);

  rmx_pkg::ctl_state_t state, state_next;
  logic boot, boot_next;
  logic m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rmx_pkg::S_INIT;
      boot     <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      boot     <= boot_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next    = state;
    boot_next     = boot;
    cmd.op        = rmx_pkg::DP_NONE;
    m_tvalid_next = m_tvalid && !m_tready;
    s_tready      = (state == rmx_pkg::S_IDLE);
    case (state)
      rmx_pkg::S_INIT: begin
        cmd.op     = rmx_pkg::DP_INIT;
        state_next = rmx_pkg::S_BRD;
      end
      rmx_pkg::S_BRD: begin
        cmd.op     = rmx_pkg::DP_BRD;
        state_next = rmx_pkg::S_BWR;
      end
      rmx_pkg::S_BWR: begin
        cmd.op     = rmx_pkg::DP_BWR;
        state_next = sts.last ? rmx_pkg::S_LEAF : rmx_pkg::S_BRD;
      end
      rmx_pkg::S_LEAF: begin
        cmd.op     = rmx_pkg::DP_LEAF;
        state_next = boot ? rmx_pkg::S_IDLE : rmx_pkg::S_OUT;
        boot_next  = 1'b0;
      end
      rmx_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = rmx_pkg::DP_LOAD;
          state_next = rmx_pkg::S_CHECK;
        end
      end
      rmx_pkg::S_CHECK: begin
        if (sts.is_query) begin
          if (sts.bad) begin
            cmd.op     = rmx_pkg::DP_REFUSE_BAD;
            state_next = rmx_pkg::S_OUT;
          end else begin
            cmd.op     = rmx_pkg::DP_QRY;
            state_next = rmx_pkg::S_QRW;
          end
        end else begin
          if (sts.full) begin
            cmd.op     = rmx_pkg::DP_REFUSE_FULL;
            state_next = rmx_pkg::S_OUT;
          end else begin
            cmd.op     = rmx_pkg::DP_APP;
            state_next = rmx_pkg::S_BRD;
          end
        end
      end
      rmx_pkg::S_QRW: begin
        cmd.op     = rmx_pkg::DP_QRW;
        state_next = rmx_pkg::S_QRN;
      end
      rmx_pkg::S_QRN: begin
        cmd.op     = rmx_pkg::DP_QRN;
        state_next = rmx_pkg::S_QALT;
      end
      rmx_pkg::S_QALT: begin
        cmd.op     = rmx_pkg::DP_QALT;
        state_next = rmx_pkg::S_QCHK;
      end
      rmx_pkg::S_QCHK: begin
        cmd.op = rmx_pkg::DP_QCHK;
        if (sts.alt_ok) begin
          state_next = sts.last ? rmx_pkg::S_QPREF : rmx_pkg::S_QALT;
        end else begin
          state_next = rmx_pkg::S_QDIR;
        end
      end
      rmx_pkg::S_QDIR: begin
        cmd.op     = rmx_pkg::DP_QDIR;
        state_next = sts.last ? rmx_pkg::S_QPREF : rmx_pkg::S_QALT;
      end
      rmx_pkg::S_QPREF: begin
        cmd.op     = rmx_pkg::DP_QPREF;
        state_next = rmx_pkg::S_QPW;
      end
      rmx_pkg::S_QPW: begin
        cmd.op     = rmx_pkg::DP_QPW;
        state_next = rmx_pkg::S_OUT;
      end
      rmx_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.op        = rmx_pkg::DP_OUT;
          m_tvalid_next = 1'b1;
          state_next    = rmx_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rmx_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == rmx_pkg::S_CHECK)
    else $error("accepted beat not checked");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    state == rmx_pkg::S_OUT && (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result beat not presented");

  a_boot_busy: assert property (@(posedge clk) disable iff (rst)
    boot |-> !s_tready && !m_tvalid)
    else $error("traffic during initial build");

endmodule

/* rtl/rmx_dp.sv */
module rmx_dp #(
  parameter int MAX_ITEMS  = rmx_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = rmx_pkg::VALUE_BITS_DEF,
  parameter int NODE_COUNT = rmx_pkg::NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  rmx_pkg::cmd_t    cmd,
  output rmx_pkg::status_t sts,
  input  logic             in_op,
  input  logic [23:0]      in_value,
  input  logic [14:0]      in_left,
  input  logic [14:0]      in_right,
  output logic [23:0]      out_data,
  output logic [1:0]       out_user
);

  localparam int PW  = $clog2(MAX_ITEMS + 1);
  localparam int NB  = $clog2(NODE_COUNT + 1);
  localparam int LVW = $clog2(VALUE_BITS);
  localparam int WW  = 2 * NB + PW;
  localparam int LW  = ((PW > 15) ? PW : 15) + 1;
  localparam int VB  = VALUE_BITS;

  logic          op_q;
  logic [23:0]   value_q;
  logic [14:0]   left_q, right_q;
  logic [PW-1:0] count, pos, limit;
  logic [VB-1:0] last_prefix, key, res;
  logic [NB-1:0] last_root, next_free, prev, cur, root;
  logic [LVW-1:0] level;
  logic [WW-1:0] w;
  logic [1:0]    st;
  logic          rd_null;

  logic          n_we, n_re, r_we, r_re, p_we, p_re;
  logic [NB-1:0] n_waddr, n_raddr;
  logic [WW-1:0] n_wdata, n_q_raw, n_q;
  logic [PW-1:0] r_raddr, p_raddr;
  logic [NB-1:0] r_q;
  logic [VB-1:0] p_q;

  logic [VB+23:0] vin_ext, res_ext;
  logic [VB-1:0]  vin;
  logic           bit_v;
  logic [NB-1:0]  w_c0, w_c1, q_c0, q_c1, alt, dir, cur_inc;
  logic [PW-1:0]  w_pos, q_pos;
  logic           alt_ok;
  logic [NB:0]    room_sum;
  logic [LW-1:0]  left_e, right_e, count1, left_m1;

  assign vin_ext = {{VB{1'b0}}, value_q};
  assign vin     = vin_ext[VB-1:0];
  assign res_ext = {24'd0, res};
  assign bit_v   = key[level];
  assign cur_inc = cur + NB'(1);

  assign n_q  = rd_null ? '0 : n_q_raw;
  assign w_c1 = w[WW-1 -: NB];
  assign w_c0 = w[PW+NB-1 -: NB];
  assign w_pos = w[PW-1:0];
  assign q_c1 = n_q[WW-1 -: NB];
  assign q_c0 = n_q[PW+NB-1 -: NB];
  assign q_pos = n_q[PW-1:0];
  assign alt  = bit_v ? w_c0 : w_c1;
  assign dir  = bit_v ? w_c1 : w_c0;
  assign alt_ok = !rd_null && (q_pos >= limit);

  assign room_sum = {1'b0, next_free} + (NB+1)'(VB + 1);
  assign left_e   = {{(LW-15){1'b0}}, left_q};
  assign right_e  = {{(LW-15){1'b0}}, right_q};
  assign count1   = {{(LW-PW){1'b0}}, count} + LW'(1);
  assign left_m1  = left_e - LW'(1);

  assign sts.is_query = op_q;
  assign sts.full = (count >= PW'(MAX_ITEMS)) || (room_sum > (NB+1)'(NODE_COUNT));
  assign sts.bad  = (left_e == '0) || (left_e > right_e) || (right_e > count1);
  assign sts.last = (level == '0);
  assign sts.alt_ok = alt_ok;

  always_comb begin
    n_we = 1'b0;
    n_re = 1'b0;
    n_waddr = cur;
    n_raddr = prev;
    n_wdata = bit_v ? {cur_inc, q_c0, pos} : {q_c1, cur_inc, pos};
    r_we = 1'b0;
    r_re = 1'b0;
    r_raddr = left_m1[PW-1:0];
    p_we = 1'b0;
    p_re = 1'b0;
    p_raddr = (w_pos > PW'(MAX_ITEMS)) ? '0 : w_pos;
    r_raddr = right_e - LW'(1) > LW'(0) ? PW'(right_e - LW'(1)) : '0;
    case (cmd.op)
      rmx_pkg::DP_BRD: begin
        n_re = 1'b1;
      end
      rmx_pkg::DP_BWR: begin
        n_we = 1'b1;
      end
      rmx_pkg::DP_LEAF: begin
        n_we    = 1'b1;
        n_wdata = {{(2*NB){1'b0}}, pos};
        r_we    = 1'b1;
        p_we    = 1'b1;
      end
      rmx_pkg::DP_QRY: begin
        r_re = 1'b1;
      end
      rmx_pkg::DP_QRW: begin
        n_re    = 1'b1;
        n_raddr = r_q;
      end
      rmx_pkg::DP_QALT: begin
        n_re    = 1'b1;
        n_raddr = alt;
      end
      rmx_pkg::DP_QCHK: begin
        n_re    = !alt_ok;
        n_raddr = dir;
      end
      rmx_pkg::DP_QPREF: begin
        p_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (n_re) begin
      rd_null <= (n_raddr == '0);
    end
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        rmx_pkg::DP_INIT: begin
          pos   <= '0;
          key   <= '0;
          prev  <= '0;
          cur   <= NB'(1);
          root  <= NB'(1);
          level <= LVW'(VB - 1);
        end
        rmx_pkg::DP_LOAD: begin
          op_q    <= in_op;
          value_q <= in_value;
          left_q  <= in_left;
          right_q <= in_right;
        end
        rmx_pkg::DP_APP: begin
          pos   <= count + PW'(1);
          key   <= last_prefix ^ vin;
          prev  <= last_root;
          cur   <= next_free + NB'(1);
          root  <= next_free + NB'(1);
          level <= LVW'(VB - 1);
        end
        rmx_pkg::DP_BWR: begin
          prev  <= bit_v ? q_c1 : q_c0;
          cur   <= cur_inc;
          level <= level - LVW'(1);
        end
        rmx_pkg::DP_LEAF: begin
          count       <= pos;
          last_prefix <= key;
          last_root   <= root;
          next_free   <= cur;
          res         <= '0;
          st          <= rmx_pkg::ST_OK;
        end
        rmx_pkg::DP_REFUSE_FULL: begin
          res <= '0;
          st  <= rmx_pkg::ST_FULL;
        end
        rmx_pkg::DP_REFUSE_BAD: begin
          res <= '0;
          st  <= rmx_pkg::ST_BAD;
        end
        rmx_pkg::DP_QRY: begin
          key   <= last_prefix ^ vin;
          limit <= left_m1[PW-1:0];
          level <= LVW'(VB - 1);
        end
        rmx_pkg::DP_QRN: begin
          w <= n_q;
        end
        rmx_pkg::DP_QCHK: begin
          if (alt_ok) begin
            w     <= n_q;
            level <= level - LVW'(1);
          end
        end
        rmx_pkg::DP_QDIR: begin
          w     <= n_q;
          level <= level - LVW'(1);
        end
        rmx_pkg::DP_QPW: begin
          res <= key ^ p_q;
          st  <= rmx_pkg::ST_OK;
        end
        rmx_pkg::DP_OUT: begin
          out_data <= res_ext[23:0];
          out_user <= st;
        end
        default: begin
        end
      endcase
    end
  end

  rmx_ram #(.WIDTH(WW), .DEPTH(NODE_COUNT + 1)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .q(n_q_raw)
  );

  rmx_ram #(.WIDTH(NB), .DEPTH(MAX_ITEMS + 1)) u_roots (
    .clk(clk), .we(r_we), .waddr(pos), .wdata(root),
    .re(r_re), .raddr(r_raddr), .q(r_q)
  );

  rmx_ram #(.WIDTH(VB), .DEPTH(MAX_ITEMS + 1)) u_prefix (
    .clk(clk), .we(p_we), .waddr(pos), .wdata(key),
    .re(p_re), .raddr(p_raddr), .q(p_q)
  );

endmodule

/* rtl/range_max_xor_persistent_trie.sv */
// Query time is set by the dependent node-memory reads of the trie walk (one or
// two per level); refused beats go straight from the check to the result beat.
// Throughput: one beat at a time; the next beat is taken while a result waits.
// Reset: synchronous; version 0 is built after reset,
// with s_tready low until it is done.
module range_max_xor_persistent_trie #(
  parameter int MAX_ITEMS  = rmx_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_BITS = rmx_pkg::VALUE_BITS_DEF,
  parameter int NODE_COUNT = rmx_pkg::NODE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // value[23:0], left_pos[38:24], right_pos[53:39], zero
  input  logic [0:0]  s_tuser,   // op[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // max_xor[23:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  rmx_pkg::cmd_t    cmd;
  rmx_pkg::status_t sts;

  rmx_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .sts(sts), .cmd(cmd)
  );

  rmx_dp #(
    .MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS), .NODE_COUNT(NODE_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_tuser[0]), .in_value(s_tdata[23:0]),
    .in_left(s_tdata[38:24]), .in_right(s_tdata[53:39]),
    .out_data(m_tdata), .out_user(m_tuser)
  );

endmodule
